// File: design/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg
// Shared types and constants of the delimited field extractor: character
// codes, status codes, register map, escape phase encoding and result word.
// ----------------------------------------------------------------------------
package dfe_pkg;

    // Fixed sizes of the datapath
    localparam int CHAR_BITS      = 8;
    localparam int FIELD_CAPACITY = 1024;
    localparam int MAX_FIELDS     = 255;
    localparam int WIDTH_BITS     = 10;
    localparam int QUEUE_DEPTH    = 4;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    typedef logic [CHAR_BITS-1:0]  char_t;
    typedef logic [WIDTH_BITS-1:0] width_t;
    typedef logic [1:0]            status_t;

    // Saturation point of the content width
    localparam width_t WIDTH_MAX = WIDTH_BITS'(FIELD_CAPACITY - 1);

    // Character codes
    localparam char_t CH_NUL   = 8'd0;
    localparam char_t CH_BS    = 8'd8;
    localparam char_t CH_TAB   = 8'd9;
    localparam char_t CH_LF    = 8'd10;
    localparam char_t CH_FF    = 8'd12;
    localparam char_t CH_CR    = 8'd13;
    localparam char_t CH_SPACE = 8'd32;
    localparam char_t CH_QUOTE = 8'd34;
    localparam char_t CH_0     = 8'd48;
    localparam char_t CH_7     = 8'd55;
    localparam char_t CH_B     = 8'd98;
    localparam char_t CH_F     = 8'd102;
    localparam char_t CH_N     = 8'd110;
    localparam char_t CH_R     = 8'd114;
    localparam char_t CH_T     = 8'd116;

    // Status codes of a done word
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NO_QUOTE = 2'd1;
    localparam status_t ST_FEW      = 2'd2;

    // Register indexes
    localparam logic REG_SEPARATOR = 1'b0;
    localparam logic REG_ESCAPE    = 1'b1;

    localparam char_t SEPARATOR_RESET = 8'd44;
    localparam char_t ESCAPE_RESET    = 8'd92;

    // Escape decoder phase
    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_SEEN  = 2'd1,
        ESC_OCTAL = 2'd2
    } esc_phase_t;

    typedef struct packed {
        char_t separator_char;
        char_t escape_char;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic    clear_first;
        logic    append_valid;
        char_t   out_char;
        logic    field_done;
        status_t status;
        width_t  content_width;
        logic    last_of_item;
    } res_t;

    // Words pushed by the front end in one cycle
    typedef struct packed {
        logic [1:0] count;
        res_t       w0;
        res_t       w1;
    } push_t;

endpackage

// File: design/dfe_in_if.sv
// ----------------------------------------------------------------------------
// dfe_in_if
// Character channel: one line character and the wanted field number per word.
// ----------------------------------------------------------------------------
interface dfe_in_if;
    logic           valid;
    logic           ready;
    dfe_pkg::char_t line_char;
    logic [7:0]     field_number;

    modport source (output valid, output line_char, output field_number, input ready);
    modport sink   (input valid, input line_char, input field_number, output ready);
endinterface

// File: design/dfe_out_if.sv
// ----------------------------------------------------------------------------
// dfe_out_if
// Result channel: append, clear-then-append and done words.
// ----------------------------------------------------------------------------
interface dfe_out_if;
    logic              valid;
    logic              ready;
    logic              clear_first;
    logic              append_valid;
    dfe_pkg::char_t    out_char;
    logic              field_done;
    dfe_pkg::status_t  status;
    dfe_pkg::width_t   content_width;
    logic              last_of_item;

    modport source (output valid, output clear_first, output append_valid,
                    output out_char, output field_done, output status,
                    output content_width, output last_of_item, input ready);
    modport sink   (input valid, input clear_first, input append_valid,
                    input out_char, input field_done, input status,
                    input content_width, input last_of_item, output ready);
endinterface

// File: design/dfe_cfg.sv
// ----------------------------------------------------------------------------
// dfe_cfg
// APB register block holding the separator and escape characters.
// ----------------------------------------------------------------------------
module dfe_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dfe_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [dfe_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [dfe_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output dfe_pkg::cfg_t                      cfg
);
    import dfe_pkg::*;

    char_t separator_reg;
    char_t escape_reg;
    logic  wr_en;
    logic  reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= SEPARATOR_RESET;
            escape_reg    <= ESCAPE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_SEPARATOR: separator_reg <= pwdata[CHAR_BITS-1:0];
                REG_ESCAPE:    escape_reg    <= pwdata[CHAR_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_index)
            REG_SEPARATOR: prdata = APB_DATA_BITS'(separator_reg);
            REG_ESCAPE:    prdata = APB_DATA_BITS'(escape_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.separator_char = separator_reg;
    assign cfg.escape_char    = escape_reg;

endmodule

// File: design/dfe_front.sv
// ----------------------------------------------------------------------------
// dfe_front
// Front end: accepts one character a cycle while the queue has room, decodes
// escapes, tracks quotes and separators, and pushes zero, one or two result
// words to the queue.
module dfe_front
(
    input  logic            clk,
    input  logic            rst_n,
    dfe_in_if.sink          in_ch,
    input  dfe_pkg::cfg_t   cfg,
    input  logic            room,
    output dfe_pkg::push_t  push
);
    import dfe_pkg::*;

    // Field tracking state touched by the character handler
    typedef struct packed {
        logic       inside_quotes;
        logic       skipping_blanks;
        logic       fresh_field;
        logic [7:0] separators_seen;
        logic [7:0] wanted_field;
        logic       field_finished;
        width_t     width_count;
    } fstate_t;

    typedef struct packed {
        fstate_t s;
        logic    v;
        res_t    r;
    } hout_t;

    // Append one character, saturating the width
    function automatic hout_t append_char(hout_t h_in, char_t c);
        hout_t h;
        h = h_in;
        h.r.clear_first = (h.s.width_count == '0);
        if (h.s.width_count < WIDTH_MAX)
            h.s.width_count = h.s.width_count + 1'b1;
        h.v               = 1'b1;
        h.r.append_valid  = 1'b1;
        h.r.out_char      = c;
        h.r.field_done    = 1'b0;
        h.r.status        = ST_OK;
        h.r.content_width = h.s.width_count;
        return h;
    endfunction

    // Done word for a failed field
    function automatic hout_t fail_field(hout_t h_in, status_t st);
        hout_t h;
        h = h_in;
        h.s.width_count    = '0;
        h.s.field_finished = 1'b1;
        h.v                = 1'b1;
        h.r.clear_first    = 1'b1;
        h.r.append_valid   = 1'b0;
        h.r.out_char       = CH_NUL;
        h.r.field_done     = 1'b1;
        h.r.status         = st;
        h.r.content_width  = '0;
        return h;
    endfunction

    // Done word for a complete field
    function automatic hout_t done_field(hout_t h_in);
        hout_t h;
        h = h_in;
        h.s.field_finished = 1'b1;
        h.v                = 1'b1;
        h.r.clear_first    = (h.s.width_count == '0);
        h.r.append_valid   = 1'b0;
        h.r.out_char       = CH_NUL;
        h.r.field_done     = 1'b1;
        h.r.status         = ST_OK;
        h.r.content_width  = h.s.width_count;
        return h;
    endfunction

    // Handle one decoded character
    function automatic hout_t handle_char(fstate_t s_in, char_t c, logic esc, char_t sep);
        hout_t h;
        logic  skip;
        h.s  = s_in;
        h.v  = 1'b0;
        h.r  = '0;
        skip = 1'b0;
        if (h.s.field_finished)
            skip = 1'b1;
        else if (h.s.skipping_blanks)
        begin
            if (!esc && c != sep && (c == CH_SPACE || c == CH_TAB))
                skip = 1'b1;
            else
                h.s.skipping_blanks = 1'b0;
        end
        if (!skip)
        begin
            if (c == CH_NUL)
            begin
                // Line end closes the field search
                if (h.s.inside_quotes)
                    h = fail_field(h, ST_NO_QUOTE);
                else if (({1'b0, h.s.separators_seen} + 9'd2) <= {1'b0, h.s.wanted_field})
                    h = fail_field(h, ST_FEW);
                else
                begin
                    if (h.s.fresh_field)
                        h.s.width_count = '0;
                    h.s.separators_seen = h.s.separators_seen + 1'b1;
                    h = done_field(h);
                end
            end
            else if (c == CH_QUOTE)
            begin
                if (esc)
                    h = append_char(h, c);
                else if (h.s.inside_quotes)
                begin
                    h.s.inside_quotes   = 1'b0;
                    h.s.skipping_blanks = 1'b1;
                end
                else
                begin
                    h.s.inside_quotes = 1'b1;
                    h.s.width_count   = '0;
                    h.s.fresh_field   = 1'b0;
                end
            end
            else if (c == sep)
            begin
                if (h.s.inside_quotes)
                    h = append_char(h, c);
                else
                begin
                    h.s.separators_seen = h.s.separators_seen + 1'b1;
                    h.s.fresh_field     = 1'b1;
                    if (h.s.separators_seen < h.s.wanted_field)
                        h.s.width_count = '0;
                    else
                        h = done_field(h);
                end
            end
            else
            begin
                if (h.s.fresh_field)
                begin
                    h.s.width_count = '0;
                    h.s.fresh_field = 1'b0;
                end
                h = append_char(h, c);
            end
        end
        return h;
    endfunction

    function automatic logic is_octal(char_t c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

    fstate_t    fs_reg, fs_next;
    esc_phase_t phase_reg, phase_next;
    logic [1:0] oct_count_reg, oct_count_next;
    logic [8:0] oct_value_reg, oct_value_next;
    logic       line_started_reg, line_started_next;

    char_t      ch;
    logic       accept;
    logic       init_v;
    logic       plain;
    logic       a_en, b_en;
    char_t      a_char;
    fstate_t    s_mid;
    hout_t      h_a, h_b;
    logic       va, vb;
    res_t       init_word;
    push_t      push_c;

    assign ch          = in_ch.line_char;
    assign in_ch.ready = room;
    assign accept      = in_ch.valid & room;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg           <= '{wanted_field: 8'd1, default: '0};
            phase_reg        <= ESC_NONE;
            oct_count_reg    <= '0;
            oct_value_reg    <= '0;
            line_started_reg <= 1'b0;
        end
        else if (accept)
        begin
            fs_reg           <= fs_next;
            phase_reg        <= phase_next;
            oct_count_reg    <= oct_count_next;
            oct_value_reg    <= oct_value_next;
            line_started_reg <= line_started_next;
        end
    end

    // Per-character step: line start, escape decoder, up to two handler passes
    always_comb
    begin
        s_mid             = fs_reg;
        phase_next        = phase_reg;
        oct_count_next    = oct_count_reg;
        oct_value_next    = oct_value_reg;
        line_started_next = line_started_reg;
        init_v            = 1'b0;
        init_word         = '0;

        // First character of a line resets the field search
        if (!line_started_reg)
        begin
            line_started_next = 1'b1;
            phase_next        = ESC_NONE;
            oct_count_next    = '0;
            oct_value_next    = '0;
            s_mid             = '0;
            s_mid.wanted_field = (32'(in_ch.field_number) > MAX_FIELDS) ?
                                 8'(MAX_FIELDS) : in_ch.field_number;
            if (s_mid.wanted_field == '0)
            begin
                init_v                  = 1'b1;
                init_word.clear_first   = 1'b1;
                init_word.field_done    = 1'b1;
                init_word.status        = ST_OK;
                s_mid.field_finished    = 1'b1;
            end
        end

        // Escape decoder
        a_en   = 1'b0;
        a_char = CH_NUL;
        plain  = 1'b0;
        case (phase_next)
            ESC_SEEN:
            begin
                phase_next = ESC_NONE;
                case (ch)
                    CH_N:    begin a_en = 1'b1; a_char = CH_LF;  end
                    CH_R:    begin a_en = 1'b1; a_char = CH_CR;  end
                    CH_T:    begin a_en = 1'b1; a_char = CH_TAB; end
                    CH_F:    begin a_en = 1'b1; a_char = CH_FF;  end
                    CH_B:    begin a_en = 1'b1; a_char = CH_BS;  end
                    default:
                    begin
                        if (ch != CH_NUL && is_octal(ch))
                        begin
                            oct_value_next = {6'd0, ch[2:0]};
                            oct_count_next = 2'd1;
                            phase_next     = ESC_OCTAL;
                        end
                        else
                        begin
                            a_en   = 1'b1;
                            a_char = ch;
                        end
                    end
                endcase
            end
            ESC_OCTAL:
            begin
                if (is_octal(ch) && oct_count_next < 2'd3)
                begin
                    oct_value_next = {oct_value_next[5:0], 3'b000} + {6'd0, ch[2:0]};
                    oct_count_next = oct_count_next + 1'b1;
                    if (oct_count_next == 2'd3)
                    begin
                        phase_next     = ESC_NONE;
                        oct_count_next = '0;
                        a_en           = 1'b1;
                        a_char         = oct_value_next[CHAR_BITS-1:0];
                    end
                end
                else
                begin
                    // Unfinished octal escape resolves, then the character is plain
                    phase_next     = ESC_NONE;
                    oct_count_next = '0;
                    a_en           = 1'b1;
                    a_char         = oct_value_next[CHAR_BITS-1:0];
                    plain          = 1'b1;
                end
            end
            default: plain = 1'b1;
        endcase

        h_a = handle_char(s_mid, a_char, 1'b1, cfg.separator_char);
        fs_next = a_en ? h_a.s : s_mid;

        // Plain character: escape start or a direct handler pass
        b_en = 1'b0;
        if (plain)
        begin
            if (ch != CH_NUL && ch == cfg.escape_char)
                phase_next = ESC_SEEN;
            else
                b_en = 1'b1;
        end
        h_b = handle_char(fs_next, ch, 1'b0, cfg.separator_char);
        if (b_en)
            fs_next = h_b.s;

        // Raw line end
        if (ch == CH_NUL)
        begin
            line_started_next = 1'b0;
            phase_next        = ESC_NONE;
            oct_count_next    = '0;
        end

        // Collect the result words
        va     = a_en & h_a.v;
        vb     = b_en & h_b.v;
        push_c = '0;
        if (init_v)
        begin
            push_c.count = 2'd1;
            push_c.w0    = init_word;
        end
        else if (va)
        begin
            push_c.w0 = h_a.r;
            if (vb)
            begin
                push_c.count = 2'd2;
                push_c.w1    = h_b.r;
            end
            else
                push_c.count = 2'd1;
        end
        else if (vb)
        begin
            push_c.count = 2'd1;
            push_c.w0    = h_b.r;
        end
        if (push_c.count == 2'd1)
            push_c.w0.last_of_item = 1'b1;
        if (push_c.count == 2'd2)
            push_c.w1.last_of_item = 1'b1;
        if (!accept)
            push_c.count = 2'd0;
        push = push_c;
    end

endmodule

// File: design/dfe_queue.sv
// ----------------------------------------------------------------------------
// dfe_queue
// Result queue between front end and output: takes up to two words a cycle,
// hands out one word a cycle while out_ch.ready is high.
// ----------------------------------------------------------------------------
module dfe_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  dfe_pkg::push_t  push,
    output logic            room,
    dfe_out_if.source       out_ch
);
    import dfe_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    res_t                 slots_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [PTR_BITS-1:0]  wr_ptr_plus1;
    logic                 pop;
    res_t                 head;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign room         = (count_reg <= CNT_BITS'(QUEUE_DEPTH - 2));
    assign pop          = out_ch.valid & out_ch.ready;

    // Pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            slots_reg[wr_ptr_reg] <= push.w0;
        if (push.count == 2'd2)
            slots_reg[wr_ptr_plus1] <= push.w1;
    end

    // Head of queue drives the result channel
    assign head                 = slots_reg[rd_ptr_reg];
    assign out_ch.valid         = (count_reg != '0);
    assign out_ch.clear_first   = head.clear_first;
    assign out_ch.append_valid  = head.append_valid;
    assign out_ch.out_char      = head.out_char;
    assign out_ch.field_done    = head.field_done;
    assign out_ch.status        = head.status;
    assign out_ch.content_width = head.content_width;
    assign out_ch.last_of_item  = head.last_of_item;

endmodule

// File: design/delimited_field_extractor.sv
// ----------------------------------------------------------------------------
// delimited_field_extractor
// Pulls one field out of a separated-values line, decoding quotes and escapes.
//
// in_ch carries one line character per word plus the wanted field number,
// which is sampled on the first character of each line; character 0 ends the
// line. out_ch carries append, clear-then-append and done words; the last
// word caused by an input character has last_of_item set. The APB port holds
// the separator (address 0) and escape (address 4) characters; pready is
// always high and writes belong to idle periods.
// The front end takes one character per cycle while the queue has room, and
// its words are written into a four-word queue whose head drives out_ch. A
// character gives zero, one or two words, and the queue drains one word a cycle
// while out_ch.ready is high, so throughput is one character a cycle while the
// results fit that rate. in_ch.ready stays high while the queue has two free
// slots, so a stalled receiver stops input once three or more words are waiting.
// Reset empties the queue, restores the default separator (comma) and escape
// (backslash), and starts a new line.
// ----------------------------------------------------------------------------
module delimited_field_extractor
(
    input  logic                               clk,
    input  logic                               rst_n,
    dfe_in_if.sink                             in_ch,
    dfe_out_if.source                          out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dfe_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [dfe_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [dfe_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import dfe_pkg::*;

    cfg_t  cfg;
    push_t push;
    logic  room;

    // Register block
    dfe_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Character decoder
    dfe_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .cfg   (cfg),
        .room  (room),
        .push  (push)
    );

    // Result queue
    dfe_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule

// File: tb/dfe_field_checker.sv
// ----------------------------------------------------------------------------
// dfe_field_checker
// Watches the character, result and register ports of the delimited field
// extractor. It keeps its own model of the field search, predicts the result
// words of every accepted character and compares each accepted result word
// with the oldest prediction.
// ----------------------------------------------------------------------------
module dfe_field_checker
    import dfe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    dfe_in_if                        in_ch,
    dfe_out_if                       out_ch,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output int                       fail_count,
    output int                       words_pending,
    output int                       words_checked,
    output int                       fields_closed
);

    localparam int MAX_WORDS    = 2;
    localparam int OCTAL_DIGITS = 3;
    localparam int SHOWN_ERRORS = 10;

    // Register copies
    char_t      sep_reg;
    char_t      esc_reg;

    // Line and field search state
    esc_phase_t esc_phase;
    logic [1:0] oct_count;
    logic [8:0] oct_value;
    logic       in_quotes;
    logic       skip_blanks;
    logic       new_field;
    logic       line_open;
    logic       search_over;
    logic [7:0] seps_seen;
    logic [7:0] want_field;
    width_t     fld_width;

    res_t       step_words[$];
    res_t       expected_words[$];

    function automatic void clear_model();
        sep_reg     = SEPARATOR_RESET;
        esc_reg     = ESCAPE_RESET;
        esc_phase   = ESC_NONE;
        oct_count   = '0;
        oct_value   = '0;
        in_quotes   = 1'b0;
        skip_blanks = 1'b0;
        new_field   = 1'b0;
        line_open   = 1'b0;
        search_over = 1'b0;
        seps_seen   = '0;
        want_field  = 8'd1;
        fld_width   = '0;
        step_words.delete();
        expected_words.delete();
    endfunction

    function automatic void emit_word(logic clr, logic app, char_t c, logic done,
                                      status_t st);
        res_t w;
        w.clear_first   = clr;
        w.append_valid  = app;
        w.out_char      = app ? c : CH_NUL;
        w.field_done    = done;
        w.status        = st;
        w.content_width = fld_width;
        w.last_of_item  = 1'b0;
        if (step_words.size() < MAX_WORDS)
            step_words.push_back(w);
    endfunction

    function automatic void add_content(char_t c);
        logic clr;
        clr = (fld_width == '0);
        if (fld_width < WIDTH_MAX)
            fld_width = fld_width + 1'b1;
        emit_word(clr, 1'b1, c, 1'b0, ST_OK);
    endfunction

    function automatic void close_failed(status_t st);
        fld_width = '0;
        emit_word(1'b1, 1'b0, CH_NUL, 1'b1, st);
        search_over = 1'b1;
    endfunction

    function automatic logic is_octal(char_t c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

    // One decoded character, plain or escaped
    function automatic void take_char(char_t c, logic escaped);
        if (search_over)
            return;
        if (skip_blanks)
        begin
            if (!escaped && c != sep_reg && (c == CH_SPACE || c == CH_TAB))
                return;
            skip_blanks = 1'b0;
        end
        if (c == CH_NUL)
        begin
            if (in_quotes)
                close_failed(ST_NO_QUOTE);
            else if (int'(seps_seen) + 2 <= int'(want_field))
                close_failed(ST_FEW);
            else
            begin
                if (new_field)
                    fld_width = '0;
                seps_seen = seps_seen + 8'd1;
                emit_word(fld_width == '0, 1'b0, CH_NUL, 1'b1, ST_OK);
                search_over = 1'b1;
            end
        end
        else if (c == CH_QUOTE)
        begin
            if (escaped)
                add_content(c);
            else if (in_quotes)
            begin
                in_quotes   = 1'b0;
                skip_blanks = 1'b1;
            end
            else
            begin
                in_quotes = 1'b1;
                fld_width = '0;
                new_field = 1'b0;
            end
        end
        else if (c == sep_reg)
        begin
            if (in_quotes)
                add_content(c);
            else
            begin
                seps_seen = seps_seen + 8'd1;
                new_field = 1'b1;
                if (seps_seen < want_field)
                    fld_width = '0;
                else
                begin
                    emit_word(fld_width == '0, 1'b0, CH_NUL, 1'b1, ST_OK);
                    search_over = 1'b1;
                end
            end
        end
        else
        begin
            if (new_field)
            begin
                fld_width = '0;
                new_field = 1'b0;
            end
            add_content(c);
        end
    endfunction

    // Predict the words of one accepted character and queue them
    function automatic void predict_char(char_t c, logic [7:0] fn);
        logic plain;
        res_t w;
        plain = 1'b0;
        step_words.delete();

        // first character of a line samples the wanted field
        if (!line_open)
        begin
            line_open   = 1'b1;
            esc_phase   = ESC_NONE;
            oct_count   = '0;
            oct_value   = '0;
            in_quotes   = 1'b0;
            skip_blanks = 1'b0;
            new_field   = 1'b0;
            seps_seen   = '0;
            search_over = 1'b0;
            fld_width   = '0;
            want_field  = (int'(fn) > MAX_FIELDS) ? 8'(MAX_FIELDS) : fn;
            if (want_field == 8'd0)
            begin
                emit_word(1'b1, 1'b0, CH_NUL, 1'b1, ST_OK);
                search_over = 1'b1;
            end
        end

        // escape decoding
        case (esc_phase)
            ESC_SEEN:
            begin
                esc_phase = ESC_NONE;
                if (c == CH_N)
                    take_char(CH_LF, 1'b1);
                else if (c == CH_R)
                    take_char(CH_CR, 1'b1);
                else if (c == CH_T)
                    take_char(CH_TAB, 1'b1);
                else if (c == CH_F)
                    take_char(CH_FF, 1'b1);
                else if (c == CH_B)
                    take_char(CH_BS, 1'b1);
                else if (c != CH_NUL && is_octal(c))
                begin
                    oct_value = 9'(c - CH_0);
                    oct_count = 2'd1;
                    esc_phase = ESC_OCTAL;
                end
                else
                    take_char(c, 1'b1);
            end
            ESC_OCTAL:
            begin
                if (is_octal(c) && int'(oct_count) < OCTAL_DIGITS)
                begin
                    oct_value = {oct_value[5:0], 3'(c - CH_0)};
                    oct_count = oct_count + 2'd1;
                    if (int'(oct_count) >= OCTAL_DIGITS)
                    begin
                        esc_phase = ESC_NONE;
                        oct_count = '0;
                        take_char(oct_value[CHAR_BITS-1:0], 1'b1);
                    end
                end
                else
                begin
                    esc_phase = ESC_NONE;
                    oct_count = '0;
                    take_char(oct_value[CHAR_BITS-1:0], 1'b1);
                    plain = 1'b1;
                end
            end
            default:
                plain = 1'b1;
        endcase

        if (plain)
        begin
            if (c != CH_NUL && c == esc_reg)
                esc_phase = ESC_SEEN;
            else
                take_char(c, 1'b0);
        end

        // raw zero always closes the line
        if (c == CH_NUL)
        begin
            line_open = 1'b0;
            esc_phase = ESC_NONE;
            oct_count = '0;
        end

        if (step_words.size() > 0)
        begin
            w = step_words.pop_back();
            w.last_of_item = 1'b1;
            step_words.push_back(w);
        end
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endfunction

    function automatic string word_text(res_t w);
        return $sformatf("clr %0b app %0b char %02h done %0b status %0d width %0d last %0b",
                         w.clear_first, w.append_valid, w.out_char, w.field_done,
                         w.status, w.content_width, w.last_of_item);
    endfunction

    // Register writes, character intake and result comparison
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        int   reg_idx;
        if (!rst_n)
        begin
            clear_model();
            fail_count    = 0;
            words_checked = 0;
            fields_closed = 0;
            words_pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = int'(paddr) / 4;
                if (reg_idx == int'(REG_SEPARATOR))
                    sep_reg = pwdata[CHAR_BITS-1:0];
                else if (reg_idx == int'(REG_ESCAPE))
                    esc_reg = pwdata[CHAR_BITS-1:0];
            end

            if (in_ch.valid && in_ch.ready)
                predict_char(in_ch.line_char, in_ch.field_number);

            if (out_ch.valid && out_ch.ready)
            begin
                got.clear_first   = out_ch.clear_first;
                got.append_valid  = out_ch.append_valid;
                got.out_char      = out_ch.out_char;
                got.field_done    = out_ch.field_done;
                got.status        = out_ch.status;
                got.content_width = out_ch.content_width;
                got.last_of_item  = out_ch.last_of_item;
                words_checked++;
                if (got.field_done === 1'b1)
                    fields_closed++;
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS)
                        $display("unexpected result word: %s", word_text(got));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.clear_first !== want.clear_first
                        || got.append_valid !== want.append_valid
                        || got.out_char !== want.out_char
                        || got.field_done !== want.field_done
                        || got.status !== want.status
                        || got.content_width !== want.content_width
                        || got.last_of_item !== want.last_of_item)
                    begin
                        fail_count++;
                        if (fail_count <= SHOWN_ERRORS)
                            $display("mismatch on word %0d: expected %s, got %s",
                                     words_checked, word_text(want), word_text(got));
                    end
                end
            end
            words_pending = expected_words.size();
        end
    end

endmodule

// File: tb/delimited_field_extractor_tb.sv
// ----------------------------------------------------------------------------
// delimited_field_extractor_tb
// Drives separated-values lines into the field extractor under several
// separator and escape settings: a short directed set of corner lines, then
// random well-formed, broken and noise lines with random idling on both
// channels, a long receiver stall and a field that overflows the width.
// A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module delimited_field_extractor_tb;
    import dfe_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int MAX_GAP        = 18;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int TIMEOUT_CYCLES = 800000;
    localparam int PHASE_ITEMS    = 50;
    localparam int HOLD_CYCLES    = 120;
    localparam int LONG_FIELD     = 1030;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int fail_count;
    int words_pending;
    int words_checked;
    int fields_closed;

    // Stimulus bookkeeping
    char_t line_q[$];
    char_t cur_sep = SEPARATOR_RESET;
    char_t cur_esc = ESCAPE_RESET;
    bit    tx_calm = 1'b0;
    bit    rx_calm = 1'b0;
    int    rx_hold = 0;
    int    chars_sent = 0;
    int    lines_sent = 0;
    int    settings_used = 1;

    dfe_in_if  in_ch ();
    dfe_out_if out_ch ();

    delimited_field_extractor i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dfe_field_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .words_checked (words_checked),
        .fields_closed (fields_closed)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int draw_gap(bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Ordinary content character: never quote, separator, escape or zero
    function automatic char_t pick_text();
        char_t c;
        do
        begin
            if ($urandom_range(0, 7) == 0)
                c = char_t'($urandom_range(1, 255));
            else
                c = char_t'($urandom_range(33, 126));
        end
        while (c == CH_QUOTE || c == cur_sep || c == cur_esc);
        return c;
    endfunction

    function automatic void add_blanks();
        repeat ($urandom_range(0, 3))
            line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    // Escape sequence: letter, octal digits, quote, separator or literal
    function automatic void add_escape();
        if (cur_esc == CH_NUL)
            return;
        line_q.push_back(cur_esc);
        case ($urandom_range(0, 6))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       line_q.push_back(CH_N);
                    1:       line_q.push_back(CH_R);
                    2:       line_q.push_back(CH_T);
                    3:       line_q.push_back(CH_F);
                    default: line_q.push_back(CH_B);
                endcase
            end
            1, 2:
            begin
                repeat ($urandom_range(1, 3))
                    line_q.push_back(CH_0 + char_t'($urandom_range(0, 7)));
            end
            3:
                line_q.push_back(CH_QUOTE);
            4:
                line_q.push_back(cur_sep != CH_NUL ? cur_sep : pick_text());
            default:
                line_q.push_back(char_t'($urandom_range(1, 255)));
        endcase
    endfunction

    // One field: bare text, quoted text or empty
    function automatic void add_field();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            repeat ($urandom_range(0, 6))
            begin
                if ($urandom_range(0, 4) == 0)
                    add_escape();
                else
                    line_q.push_back(pick_text());
            end
        end
        else if (kind < 8)
        begin
            if ($urandom_range(0, 5) == 0)
                add_blanks();
            line_q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6))
            begin
                case ($urandom_range(0, 5))
                    0:       add_escape();
                    1:       line_q.push_back(cur_sep != CH_NUL ? cur_sep : pick_text());
                    2:       line_q.push_back(CH_SPACE);
                    default: line_q.push_back(pick_text());
                endcase
            end
            line_q.push_back(CH_QUOTE);
            add_blanks();
            // something right after the closing quote and its blanks
            case ($urandom_range(0, 5))
                0:       add_escape();
                1:       line_q.push_back(pick_text());
                default: ;
            endcase
        end
    endfunction

    // Well-formed line with random content, sometimes broken at the end
    function automatic void build_line(output logic [7:0] fn);
        int nf;
        int k;
        int cut;
        nf = $urandom_range(1, 6);
        for (int i = 0; i < nf; i++)
        begin
            add_field();
            if (i < nf - 1 && cur_sep != CH_NUL)
                line_q.push_back(cur_sep);
        end
        case ($urandom_range(0, 11))
            0:
            begin
                if (line_q.size() > 1)
                begin
                    cut = $urandom_range(1, line_q.size() - 1);
                    while (line_q.size() > cut)
                        void'(line_q.pop_back());
                end
            end
            1:
                if (cur_esc != CH_NUL)
                    line_q.push_back(cur_esc);
            2:
            begin
                if (cur_esc != CH_NUL)
                begin
                    line_q.push_back(cur_esc);
                    line_q.push_back(CH_0 + char_t'($urandom_range(0, 7)));
                end
            end
            3:
                line_q.push_back(CH_QUOTE);
            default: ;
        endcase
        line_q.push_back(CH_NUL);
        k = $urandom_range(0, 19);
        if (k == 0)
            fn = 8'd0;
        else if (k == 1)
            fn = 8'd255;
        else if (k == 2)
            fn = 8'($urandom_range(0, 255));
        else
            fn = 8'($urandom_range(1, nf + 1));
    endfunction

    // Offer one character word and wait until it is taken
    task automatic put_char(char_t c, logic [7:0] fn);
        int gap;
        gap = draw_gap(tx_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.line_char    <= c;
        in_ch.field_number <= fn;
        do @(posedge clk); while (!in_ch.ready);
        chars_sent++;
    endtask

    // Field number counts only on the first character; the rest get noise
    task automatic send_line(logic [7:0] fn);
        foreach (line_q[i])
            put_char(line_q[i], (i == 0) ? fn : 8'($urandom_range(0, 255)));
        line_q.delete();
        lines_sent++;
    endtask

    // Stop offering and wait for every predicted word
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (words_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, char_t value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'(4 * int'(idx));
        pwdata  <= {(APB_DATA_BITS - CHAR_BITS)'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(char_t sep, char_t esc);
        settle();
        write_reg(REG_SEPARATOR, sep);
        write_reg(REG_ESCAPE, esc);
        cur_sep = sep;
        cur_esc = esc;
        settings_used++;
    endtask

    // Random lines until the phase quota of characters has gone out
    task automatic run_phase(int quota);
        int         stop_at;
        logic [7:0] fn;
        stop_at = chars_sent + quota;
        while (chars_sent < stop_at)
        begin
            if ($urandom_range(0, 5) == 0)
                tx_calm = $urandom_range(0, 1);
            if ($urandom_range(0, 5) == 0)
                rx_calm = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 24))
                    line_q.push_back(char_t'($urandom_range(0, 255)));
                line_q.push_back(CH_NUL);
                fn = 8'($urandom_range(0, 255));
            end
            else
                build_line(fn);
            send_line(fn);
            if ($urandom_range(0, 40) == 0)
                settle();
        end
    endtask

    // Receiver: random stall before each word, long hold on request
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            else
                stall = draw_gap(rx_calm);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Run limit
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("FAIL");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int waited;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.line_char    = '0;
        in_ch.field_number = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // field number zero: done at once, rest of the line ignored
        line_q.push_back(pick_text());
        line_q.push_back(CH_NUL);
        send_line(8'd0);

        // top code, escaped LF and three-digit octal in quotes, blanks after
        // the closing quote, done at the second separator
        line_q.push_back(8'hFF);
        line_q.push_back(cur_sep);
        line_q.push_back(CH_QUOTE);
        line_q.push_back(cur_esc);
        line_q.push_back(CH_N);
        line_q.push_back(cur_esc);
        line_q.push_back(CH_0 + 8'd1);
        line_q.push_back(CH_0);
        line_q.push_back(CH_0 + 8'd1);
        line_q.push_back(CH_QUOTE);
        line_q.push_back(CH_SPACE);
        line_q.push_back(cur_sep);
        line_q.push_back(CH_NUL);
        send_line(8'd2);

        // octal escape pending at line end, too few fields for the top number
        line_q.push_back(cur_esc);
        line_q.push_back(CH_7);
        line_q.push_back(CH_NUL);
        send_line(8'd255);

        // unclosed quote
        line_q.push_back(CH_QUOTE);
        line_q.push_back(CH_NUL);
        send_line(8'd1);

        // escape decoding to zero ends the search
        line_q.push_back(cur_esc);
        line_q.push_back(CH_0);
        line_q.push_back(CH_0);
        line_q.push_back(CH_0);
        line_q.push_back(CH_NUL);
        send_line(8'd1);

        // random phases over several register settings
        run_phase(PHASE_ITEMS);
        set_config(CH_TAB, 8'h2F);
        run_phase(PHASE_ITEMS);
        set_config(CH_NUL, CH_NUL);
        run_phase(PHASE_ITEMS);
        set_config(8'hFF, 8'hFF);
        run_phase(PHASE_ITEMS);
        set_config(CH_QUOTE, ESCAPE_RESET);
        run_phase(PHASE_ITEMS);
        set_config(char_t'($urandom_range(1, 255)), char_t'($urandom_range(1, 255)));
        run_phase(PHASE_ITEMS);
        set_config(SEPARATOR_RESET, ESCAPE_RESET);

        // receiver holds off while a burst of appends fills the queue
        settle();
        tx_calm = 1'b1;
        rx_hold = HOLD_CYCLES;
        repeat (40) line_q.push_back(pick_text());
        line_q.push_back(CH_NUL);
        send_line(8'd1);
        settle();

        // one field longer than the width counter can hold
        rx_calm = 1'b1;
        repeat (LONG_FIELD) line_q.push_back(pick_text());
        line_q.push_back(CH_NUL);
        send_line(8'd1);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        run_phase(PHASE_ITEMS);

        // drain
        @(negedge clk);
        in_ch.valid <= 1'b0;
        waited = 0;
        while (words_pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);

        $display("covered %0d characters in %0d lines under %0d register settings",
                 chars_sent, lines_sent, settings_used);
        $display("%0d result words compared, %0d field completions, %0d mismatches, %0d left",
                 words_checked, fields_closed, fail_count, words_pending);
        if (fail_count == 0 && words_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
